// ----- sv/kmp_pkg.sv -----
// shared types, register codes and pattern byte access for the kmp stream matcher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kmp_pkg;

  localparam int LEN_BITS       = 5;
  localparam int PAT_BYTES      = 16;
  localparam int OUT_BITS       = 32;
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_INDEX_BITS = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_PATTERN_LOW    = 2'd1,
    REG_PATTERN_HIGH   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       first_of_text;
  } kmp_in_t;

  typedef struct packed {
    logic                matched;
    logic [OUT_BITS-1:0] match_start;
    logic [OUT_BITS-1:0] text_position;
  } kmp_out_t;

  // 1-based byte k of the concatenated pattern
  function automatic logic [7:0] pattern_byte(input logic [8*PAT_BYTES-1:0] pattern,
                                              input logic [LEN_BITS-1:0] k);
    logic [3:0] i;
    i = 4'(k - 5'd1);
    return pattern[{i, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

// ----- sv/kmp_table.sv -----
// configuration registers and failure table derivation, one step per cycle
// depends on kmp_pkg
`timescale 1ns / 1ps
`default_nettype none

module kmp_table #(
  parameter int PATTERN_MAX = 16,
  parameter int IDX_BITS    = 5
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write_enable,
  input  wire logic [kmp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [kmp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic [IDX_BITS-1:0]                rd_idx,
  output logic [7:0]                              rd_byte,
  output logic [IDX_BITS-1:0]                     rd_fail,
  output logic [IDX_BITS-1:0]                     len_eff,
  output logic                                    busy
);
  import kmp_pkg::*;

  localparam int TBL_DEPTH = 1 << IDX_BITS;

  typedef enum logic [1:0] {
    TB_IDLE   = 2'b01,
    TB_DERIVE = 2'b10
  } tb_state_t;

  tb_state_t             state;
  logic [LEN_BITS-1:0]   len_reg;
  logic [63:0]           pat_low;
  logic [63:0]           pat_high;
  logic [IDX_BITS-1:0]   dj;
  logic [IDX_BITS-1:0]   dt;
  logic [IDX_BITS-1:0]   tbl [TBL_DEPTH];

  logic [LEN_BITS-1:0]   len_clamped;
  logic [127:0]          pattern;
  logic [IDX_BITS-1:0]   tbl_addr;
  logic [IDX_BITS-1:0]   tbl_out;
  logic [IDX_BITS-1:0]   byte_addr;
  logic [7:0]            byte_a;
  logic [7:0]            byte_t;
  logic                  cfg_hit;

  always_comb begin
    if (len_reg == '0) begin
      len_clamped = LEN_BITS'(1);
    end else if (len_reg > LEN_BITS'(PATTERN_MAX)) begin
      len_clamped = LEN_BITS'(PATTERN_MAX);
    end else begin
      len_clamped = len_reg;
    end
  end

  assign len_eff   = IDX_BITS'(len_clamped);
  assign pattern   = {pat_high, pat_low};
  assign busy      = (state == TB_DERIVE);
  assign tbl_addr  = busy ? dt : rd_idx;
  assign tbl_out   = (tbl_addr <= IDX_BITS'(1)) ? '0 : tbl[tbl_addr];
  assign byte_addr = busy ? dj : rd_idx;
  assign byte_a    = pattern_byte(pattern, LEN_BITS'(byte_addr));
  assign byte_t    = pattern_byte(pattern, LEN_BITS'(dt));
  assign rd_byte   = byte_a;
  assign rd_fail   = tbl_out;
  assign cfg_hit   = cfg_write_enable && (cfg_index inside {REG_PATTERN_LENGTH,
                                                            REG_PATTERN_LOW,
                                                            REG_PATTERN_HIGH});

  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg  <= LEN_BITS'(1);
      pat_low  <= '0;
      pat_high <= '0;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: len_reg  <= cfg_data[LEN_BITS-1:0];
        REG_PATTERN_LOW:    pat_low  <= cfg_data;
        REG_PATTERN_HIGH:   pat_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TB_DERIVE;
      dj    <= IDX_BITS'(1);
      dt    <= '0;
    end else if (cfg_hit) begin
      state <= TB_DERIVE;
      dj    <= IDX_BITS'(1);
      dt    <= '0;
    end else begin
      case (state)
        TB_IDLE: ;
        TB_DERIVE: begin
          if (dj >= len_eff) begin
            state <= TB_IDLE;
          end else if (dt == '0 || byte_a == byte_t) begin
            dj <= dj + IDX_BITS'(1);
            dt <= dt + IDX_BITS'(1);
          end else begin
            dt <= tbl_out;
          end
        end
        default: state <= TB_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (busy && dj < len_eff && (dt == '0 || byte_a == byte_t)) begin
      tbl[dj + IDX_BITS'(1)] <= dt + IDX_BITS'(1);
    end
  end

endmodule

`default_nettype wire

// ----- sv/kmp_front.sv -----
// input side: accepts text bytes, tracks the saturating text position
// depends on kmp_pkg; feeds the item queue
`timescale 1ns / 1ps
`default_nettype none

module kmp_front #(
  parameter int POSITION_BITS = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      text_valid,
  output logic                           text_ready,
  input  wire kmp_pkg::kmp_in_t          text,
  input  wire logic                      table_busy,
  output logic                           push_valid,
  input  wire logic                      push_ready,
  output logic [POSITION_BITS+8:0]       push_data
);
  import kmp_pkg::*;

  logic [POSITION_BITS-1:0] counter;
  logic [POSITION_BITS-1:0] counter_next;
  logic                     accept;

  assign text_ready = push_ready && !table_busy;
  assign accept     = text_valid && text_ready;
  assign push_valid = text_valid && !table_busy;

  always_comb begin
    if (text.first_of_text) begin
      counter_next = POSITION_BITS'(1);
    end else if (counter == '1) begin
      counter_next = counter;
    end else begin
      counter_next = counter + POSITION_BITS'(1);
    end
  end

  assign push_data = {counter_next, text.first_of_text, text.text_char};

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
    end else if (accept) begin
      counter <= counter_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/kmp_queue.sv -----
// short fifo between the front and the matching engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module kmp_queue #(
  parameter int DATA_BITS = 41,
  parameter int DEPTH     = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push_valid,
  output logic                      push_ready,
  input  wire logic [DATA_BITS-1:0] push_data,
  output logic                      pop_valid,
  input  wire logic                 pop_ready,
  output logic [DATA_BITS-1:0]      pop_data
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_BITS-1:0] slots [DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr;
  logic [PTR_BITS-1:0]  rd_ptr;
  logic [PTR_BITS:0]    count;
  logic                 push;
  logic                 pop;

  assign push_ready = (count != (PTR_BITS+1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_BITS+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_BITS+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- sv/kmp_engine.sv -----
// matching engine: one compare per cycle unless stalled; failure table walk on mismatch
// depends on kmp_pkg and the failure table read port; owns the result register
`timescale 1ns / 1ps
`default_nettype none

module kmp_engine #(
  parameter int IDX_BITS      = 5,
  parameter int POSITION_BITS = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      pop_valid,
  output logic                           pop_ready,
  input  wire logic [POSITION_BITS+8:0]  pop_data,
  input  wire logic                      table_busy,
  input  wire logic [IDX_BITS-1:0]       len_eff,
  output logic [IDX_BITS-1:0]            rd_idx,
  input  wire logic [7:0]                rd_byte,
  input  wire logic [IDX_BITS-1:0]       rd_fail,
  output logic                           result_valid,
  input  wire logic                      result_ready,
  output kmp_pkg::kmp_out_t              result
);
  import kmp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } eng_state_t;

  eng_state_t               state;
  logic [IDX_BITS-1:0]      pat_pos;
  logic [POSITION_BITS-1:0] found;
  logic [IDX_BITS-1:0]      scan_j;
  logic [7:0]               scan_c;
  logic [POSITION_BITS-1:0] scan_pos;

  logic                     in_idle;
  logic [7:0]               head_c;
  logic                     head_first;
  logic [POSITION_BITS-1:0] head_pos;
  logic [IDX_BITS-1:0]      pp_cur;
  logic [IDX_BITS-1:0]      j_init;
  logic [IDX_BITS-1:0]      cur_j;
  logic [7:0]               cur_c;
  logic [POSITION_BITS-1:0] cur_pos;
  logic [POSITION_BITS-1:0] found_cur;
  logic [POSITION_BITS-1:0] found_calc;
  logic [POSITION_BITS-1:0] found_new;
  logic [IDX_BITS-1:0]      j_inc;
  logic [IDX_BITS-1:0]      pp_new;
  logic                     eq;
  logic                     searching;
  logic                     hit;
  logic                     resolved;
  logic                     out_free;
  logic                     active;
  logic                     finish;
  logic [63:0]              found_wide;
  logic [63:0]              pos_wide;

  assign in_idle    = (state == ST_IDLE);
  assign head_c     = pop_data[7:0];
  assign head_first = pop_data[8];
  assign head_pos   = pop_data[POSITION_BITS+8:9];

  assign pp_cur = head_first ? IDX_BITS'(1) : pat_pos;
  assign j_init = (pp_cur == '0 || pp_cur > len_eff) ? IDX_BITS'(1) : pp_cur;

  assign cur_j     = in_idle ? j_init : scan_j;
  assign cur_c     = in_idle ? head_c : scan_c;
  assign cur_pos   = in_idle ? head_pos : scan_pos;
  assign found_cur = (in_idle && head_first) ? '0 : found;
  assign rd_idx    = cur_j;

  assign searching  = (found_cur == '0);
  assign eq         = (cur_c == rd_byte);
  assign j_inc      = cur_j + IDX_BITS'(1);
  assign hit        = searching && eq && (j_inc > len_eff);
  assign resolved   = !searching || eq || (rd_fail == '0);
  assign pp_new     = eq ? j_inc : IDX_BITS'(1);
  assign found_calc = cur_pos - POSITION_BITS'(len_eff) + POSITION_BITS'(1);
  assign found_new  = hit ? found_calc : found_cur;

  assign out_free  = !result_valid || result_ready;
  assign active    = in_idle ? (pop_valid && !table_busy) : 1'b1;
  assign finish    = active && resolved && out_free;
  assign pop_ready = in_idle && !table_busy && (!resolved || out_free);

  assign found_wide = 64'(found_new);
  assign pos_wide   = 64'(cur_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pat_pos      <= IDX_BITS'(1);
      found        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (finish) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (active) begin
            if (finish) begin
              found <= found_new;
              if (searching) begin
                pat_pos <= pp_new;
              end
            end else if (!resolved) begin
              found <= found_cur;
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (finish) begin
            found   <= found_new;
            pat_pos <= pp_new;
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (active && !resolved) begin
      scan_j <= rd_fail;
    end
    if (in_idle && active && !resolved) begin
      scan_c   <= head_c;
      scan_pos <= head_pos;
    end
    if (finish) begin
      result.matched       <= hit;
      result.match_start   <= found_wide[OUT_BITS-1:0];
      result.text_position <= pos_wide[OUT_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- sv/kmp_stream_matcher.sv -----
// a byte's result passes the item queue and the result register, plus one scan step per failure
//   table step to a nonzero position; throughput 1 byte per cycle plus those steps unless stalled
// reset: length 1, all-zero pattern, search at pattern position 1 and text position 0
// after reset or any pattern register write the failure table is rebuilt while text_ready stays low
`timescale 1ns / 1ps
`default_nettype none

module kmp_stream_matcher #(
  parameter int PATTERN_MAX   = 16,
  parameter int POSITION_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               text_valid,
  output logic                                    text_ready,
  input  wire kmp_pkg::kmp_in_t                   text,
  output logic                                    result_valid,
  input  wire logic                               result_ready,
  output kmp_pkg::kmp_out_t                       result,
  input  wire logic                               cfg_write_enable,
  input  wire logic [kmp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [kmp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import kmp_pkg::*;

  localparam int IDX_BITS  = $clog2(PATTERN_MAX + 2);
  localparam int ITEM_BITS = POSITION_BITS + 9;

  logic                 table_busy;
  logic [IDX_BITS-1:0]  len_eff;
  logic [IDX_BITS-1:0]  rd_idx;
  logic [7:0]           rd_byte;
  logic [IDX_BITS-1:0]  rd_fail;
  logic                 push_valid;
  logic                 push_ready;
  logic [ITEM_BITS-1:0] push_data;
  logic                 pop_valid;
  logic                 pop_ready;
  logic [ITEM_BITS-1:0] pop_data;

  kmp_table #(
    .PATTERN_MAX (PATTERN_MAX),
    .IDX_BITS    (IDX_BITS)
  ) u_table (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .rd_idx           (rd_idx),
    .rd_byte          (rd_byte),
    .rd_fail          (rd_fail),
    .len_eff          (len_eff),
    .busy             (table_busy)
  );

  kmp_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text       (text),
    .table_busy (table_busy),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  kmp_queue #(
    .DATA_BITS (ITEM_BITS),
    .DEPTH     (2)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  kmp_engine #(
    .IDX_BITS      (IDX_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .table_busy   (table_busy),
    .len_eff      (len_eff),
    .rd_idx       (rd_idx),
    .rd_byte      (rd_byte),
    .rd_fail      (rd_fail),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

// ----- verif/kmp_stream_matcher_tb.sv -----
// self-checking testbench for kmp_stream_matcher: a directed table, then random pattern
// phases under varying source and sink throttling, checked against a local search model
// or, for typed rows, fixed results; depends on kmp_pkg and kmp_stream_matcher
`timescale 1ns / 1ps

module kmp_stream_matcher_tb;
  import kmp_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED = 2'd3;
  localparam int          MAX_LEN      = 16;
  localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;
  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          RANDOM_ITEMS = 1000;
  localparam int          PHASE_ITEMS  = 64;
  localparam int          HOLD_CYCLES  = 200;
  localparam int          DRAIN_CYCLES = 40;
  localparam kmp_in_t     NO_CHAR      = '0;
  localparam kmp_out_t    UNTYPED      = '0;

  typedef enum logic {ROW_TEXT, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic [CFG_INDEX_BITS-1:0]   index;
    logic [CFG_DATA_BITS-1:0]    data;
    kmp_in_t                     item;
    logic                        typed;
    kmp_out_t                    want;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 31;

  directed_row_t directed [DIRECTED_ROWS] = '{
    // reset pattern: one zero byte
    '{ROW_TEXT,  REG_PATTERN_LENGTH, 64'd0, '{8'h00, 1'b1}, 1'b1, '{1'b1, 32'd1, 32'd1}},
    '{ROW_TEXT,  REG_PATTERN_LENGTH, 64'd0, '{8'hFF, 1'b0}, 1'b1, '{1'b0, 32'd1, 32'd2}},
    '{ROW_TEXT,  REG_PATTERN_LENGTH, 64'd0, '{8'h55, 1'b1}, 1'b1, '{1'b0, 32'd0, 32'd1}},
    '{ROW_TEXT,  REG_PATTERN_LENGTH, 64'd0, '{8'h00, 1'b0}, 1'b1, '{1'b1, 32'd2, 32'd2}},
    // overlapping prefix pattern, forces failure link walks
    '{ROW_WRITE, REG_PATTERN_LENGTH, 64'd6, NO_CHAR, 1'b0, UNTYPED},
    '{ROW_WRITE, REG_PATTERN_LOW, 64'h0000_4341_4241_4241, NO_CHAR, 1'b0, UNTYPED},
    '{ROW_TEXT,  REG_PATTERN_LENGTH, 64'd0, '{8'h41, 1'b1}, 1'b0, UNTYPED},
    '{ROW_TEXT,  REG_PATTERN_LENGTH, 64'd0, '{8'h42, 1'b0}, 1'b0, UNTYPED},
    '{ROW_TEXT,  REG_PATTERN_LENGTH, 64'd0, '{8'h41, 1'b0}, 1'b0, UNTYPED},
    '{ROW_TEXT,  REG_PATTERN_LENGTH, 64'd0, '{8'h42, 1'b0}, 1'b0, UNTYPED},
    '{ROW_TEXT,  REG_PATTERN_LENGTH, 64'd0, '{8'h41, 1'b0}, 1'b0, UNTYPED},
    '{ROW_TEXT,  REG_PATTERN_LENGTH, 64'd0, '{8'h42, 1'b0}, 1'b0, UNTYPED},
    '{ROW_TEXT,  REG_PATTERN_LENGTH, 64'd0, '{8'h41, 1'b0}, 1'b0, UNTYPED},
    '{ROW_TEXT,  REG_PATTERN_LENGTH, 64'd0, '{8'h43, 1'b0}, 1'b0, UNTYPED},
    // oversized length clamps to 16, unmapped index must not touch the pattern
    '{ROW_WRITE, REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF, NO_CHAR, 1'b0, UNTYPED},
    '{ROW_WRITE, REG_PATTERN_LOW,    64'hFFFF_FFFF_FFFF_FFFF, NO_CHAR, 1'b0, UNTYPED},
    '{ROW_WRITE, REG_PATTERN_HIGH,   64'hFFFF_FFFF_FFFF_FFFF, NO_CHAR, 1'b0, UNTYPED},
    '{ROW_WRITE, REG_UNMAPPED,       64'd0, NO_CHAR, 1'b0, UNTYPED},
    '{ROW_TEXT,  REG_PATTERN_LENGTH, 64'd0, '{8'hFF, 1'b1}, 1'b0, UNTYPED},
    '{ROW_TEXT,  REG_PATTERN_LENGTH, 64'd0, '{8'hFF, 1'b0}, 1'b0, UNTYPED},
    '{ROW_TEXT,  REG_PATTERN_LENGTH, 64'd0, '{8'hFF, 1'b0}, 1'b0, UNTYPED},
    '{ROW_TEXT,  REG_PATTERN_LENGTH, 64'd0, '{8'hFF, 1'b0}, 1'b0, UNTYPED},
    '{ROW_TEXT,  REG_PATTERN_LENGTH, 64'd0, '{8'hFF, 1'b0}, 1'b0, UNTYPED},
    '{ROW_TEXT,  REG_PATTERN_LENGTH, 64'd0, '{8'hFF, 1'b0}, 1'b0, UNTYPED},
    '{ROW_TEXT,  REG_PATTERN_LENGTH, 64'd0, '{8'hFF, 1'b0}, 1'b0, UNTYPED},
    '{ROW_TEXT,  REG_PATTERN_LENGTH, 64'd0, '{8'hFF, 1'b0}, 1'b0, UNTYPED},
    '{ROW_TEXT,  REG_PATTERN_LENGTH, 64'd0, '{8'hFF, 1'b0}, 1'b0, UNTYPED},
    '{ROW_TEXT,  REG_PATTERN_LENGTH, 64'd0, '{8'hFF, 1'b0}, 1'b0, UNTYPED},
    '{ROW_TEXT,  REG_PATTERN_LENGTH, 64'd0, '{8'hFF, 1'b0}, 1'b0, UNTYPED},
    // zero length acts as one, search position beyond it restarts at 1
    '{ROW_WRITE, REG_PATTERN_LENGTH, 64'd0, NO_CHAR, 1'b0, UNTYPED},
    '{ROW_TEXT,  REG_PATTERN_LENGTH, 64'd0, '{8'hFF, 1'b0}, 1'b1, '{1'b1, 32'd12, 32'd12}}
  };

  logic                      clk;
  logic                      rst;
  logic                      text_valid;
  logic                      text_ready;
  kmp_in_t                   text;
  logic                      result_valid;
  logic                      result_ready;
  kmp_out_t                  result;
  logic                      cfg_write_enable;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  kmp_stream_matcher i_dut (
    .clk              (clk),
    .rst              (rst),
    .text_valid       (text_valid),
    .text_ready       (text_ready),
    .text             (text),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .result           (result),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // search model state
  logic [4:0]  length_reg;
  logic [63:0] pattern_lo;
  logic [63:0] pattern_hi;
  logic [4:0]  fail_link [0:MAX_LEN];
  int          search_pos;
  logic [31:0] chars_seen;
  logic [31:0] first_hit;

  kmp_out_t awaited_matches [$];
  logic     use_typed;
  kmp_out_t typed_want;
  int       tx_idle_pct;
  int       rx_stall_pct;
  bit       hold_req;
  int       hold_left;
  int       errors;
  int       cycle_count = 0;

  function automatic int active_length();
    if (length_reg == 5'd0) return 1;
    if (length_reg > MAX_LEN) return MAX_LEN;
    return int'(length_reg);
  endfunction

  function automatic logic [7:0] pattern_char(int k);
    int i;
    i = (k - 1) & 15;
    return (i < 8) ? pattern_lo[8*i +: 8] : pattern_hi[8*(i-8) +: 8];
  endfunction

  function automatic void rebuild_links();
    int len;
    int j;
    int t;
    len = active_length();
    j = 1;
    t = 0;
    for (int k = 0; k <= MAX_LEN; k++) fail_link[k] = 5'd0;
    while (j < len) begin
      if (t == 0 || pattern_char(j) == pattern_char(t)) begin
        fail_link[j+1] = 5'(t + 1);
        j++;
        t++;
      end else begin
        t = int'(fail_link[t]);
      end
    end
  endfunction

  function automatic void write_model_register(logic [CFG_INDEX_BITS-1:0] index,
                                               logic [CFG_DATA_BITS-1:0] data);
    case (index)
      REG_PATTERN_LENGTH: length_reg = data[4:0];
      REG_PATTERN_LOW:    pattern_lo = data;
      REG_PATTERN_HIGH:   pattern_hi = data;
      default:            return;
    endcase
    rebuild_links();
  endfunction

  function automatic kmp_out_t advance_search(kmp_in_t it);
    kmp_out_t r;
    int       len;
    int       j;
    len = active_length();
    r.matched = 1'b0;
    if (it.first_of_text) begin
      search_pos = 1;
      chars_seen = '0;
      first_hit  = '0;
    end
    if (chars_seen != COUNT_MAX) chars_seen++;
    if (first_hit == '0) begin
      j = search_pos;
      if (j < 1 || j > len) j = 1;
      while (j != 0 && it.text_char != pattern_char(j)) j = int'(fail_link[j]);
      j++;
      if (j > len) begin
        first_hit = chars_seen - 32'(len) + 32'd1;
        r.matched = 1'b1;
      end
      search_pos = j;
    end
    r.match_start   = first_hit;
    r.text_position = chars_seen;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    if (errors < 40) $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $time);
    errors++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result check first, then the accepted character
  always @(posedge clk) begin : match_watch
    kmp_out_t want;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (awaited_matches.size() == 0) begin
          report_mismatch("result with nothing awaited", 0, 0);
        end else begin
          want = awaited_matches.pop_front();
          if (result.matched !== want.matched)
            report_mismatch("matched", want.matched, result.matched);
          if (result.match_start !== want.match_start)
            report_mismatch("match_start", want.match_start, result.match_start);
          if (result.text_position !== want.text_position)
            report_mismatch("text_position", want.text_position, result.text_position);
        end
      end
      if (text_valid && text_ready) begin
        want = advance_search(text);
        awaited_matches.push_back(use_typed ? typed_want : want);
      end
    end
  end

  // sink throttling, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  task automatic offer_char(kmp_in_t it, logic typed, kmp_out_t want);
    @(negedge clk);
    use_typed  = typed;
    typed_want = want;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      text_valid <= 1'b0;
      @(negedge clk);
    end
    text_valid <= 1'b1;
    text       <= it;
    do @(posedge clk); while (!text_ready);
  endtask

  task automatic write_register(logic [CFG_INDEX_BITS-1:0] index,
                                logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index        <= index;
    cfg_data         <= data;
    write_model_register(index, data);
    @(negedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    text_valid <= 1'b0;
    while (awaited_matches.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    int           row;
    int           items;
    int           phase;
    int           phase_items;
    int           pick;
    int           plen;
    int           prefix;
    int           tail;
    int           tlen;
    bit           planted;
    bit           noisy;
    bit           restart;
    logic [63:0]  len_data;
    logic [127:0] motif_bits;
    logic [7:0]   alpha [3];
    kmp_in_t      it;

    rst              = 1'b1;
    text_valid       = 1'b0;
    text             = '0;
    result_ready     = 1'b0;
    cfg_write_enable = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    use_typed        = 1'b0;
    typed_want       = '0;
    tx_idle_pct      = 0;
    rx_stall_pct     = 0;
    hold_req         = 1'b0;
    hold_left        = 0;
    errors           = 0;
    length_reg       = 5'd1;
    pattern_lo       = '0;
    pattern_hi       = '0;
    search_pos       = 1;
    chars_seen       = '0;
    first_hit        = '0;
    rebuild_links();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (row = 0; row < DIRECTED_ROWS; row++) begin
      if (directed[row].kind == ROW_WRITE) begin
        wait_idle();
        write_register(directed[row].index, directed[row].data);
      end else begin
        offer_char(directed[row].item, directed[row].typed, directed[row].want);
      end
    end

    items = 0;
    phase = 0;
    while (items < RANDOM_ITEMS) begin
      wait_idle();
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 86; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 86; end
        default: begin tx_idle_pct = 10; rx_stall_pct = 10; end
      endcase
      for (int k = 0; k < 3; k++) alpha[k] = 8'($urandom);

      pick = $urandom_range(0, 9);
      case (pick)
        0: len_data = 64'd16;
        1: len_data = {$urandom, 27'($urandom),
                       $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31))};
        default: len_data = 64'($urandom_range(1, 6));
      endcase
      if (len_data[4:0] == 5'd0) plen = 1;
      else if (len_data[4:0] > MAX_LEN) plen = MAX_LEN;
      else plen = int'(len_data[4:0]);

      noisy = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < MAX_LEN; k++)
        motif_bits[8*k +: 8] = noisy ? 8'($urandom) : alpha[$urandom_range(0, 1)];

      write_register(REG_PATTERN_LENGTH, len_data);
      write_register(REG_PATTERN_LOW, motif_bits[63:0]);
      write_register(REG_PATTERN_HIGH, motif_bits[127:64]);
      if ($urandom_range(0, 3) == 0) write_register(REG_UNMAPPED, {$urandom, $urandom});
      if (phase % 4 == 0) hold_req = 1'b1;

      // the first text of a phase sometimes carries on the old search
      restart = ($urandom_range(0, 3) != 0);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        prefix  = $urandom_range(0, 8);
        planted = $urandom_range(0, 1);
        tail    = $urandom_range(0, 6);
        tlen    = prefix + (planted ? plen : 0) + tail;
        if (tlen == 0) tlen = 1;
        for (int k = 0; k < tlen; k++) begin
          if (planted && k >= prefix && k < prefix + plen)
            it.text_char = motif_bits[8*(k-prefix) +: 8];
          else if ($urandom_range(0, 19) == 0)
            it.text_char = 8'($urandom);
          else
            it.text_char = alpha[$urandom_range(0, 2)];
          it.first_of_text = (k == 0) ? restart : ($urandom_range(0, 49) == 0);
          offer_char(it, 1'b0, UNTYPED);
          phase_items++;
          items++;
        end
        restart = 1'b1;
      end
      phase++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
